[hdl/mccd_pkg.sv]
// mccd_pkg: shared constants and types for the minimum coin change unit
// no dependencies
`timescale 1ns / 1ps

package mccd_pkg;

  localparam int unsigned MAX_AMOUNT_DEF = 4095;
  localparam int unsigned MAX_COINS_DEF  = 16;

  localparam int unsigned COIN_W = 31;
  localparam int unsigned AMT_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned OUT_W  = 12;

  localparam logic [CNT_W-1:0] INF_MARK = '1;

  typedef struct packed {
    logic             upd;
    logic [CNT_W-1:0] val;
  } relax_res_t;

endpackage

[hdl/min_coin_change_dp_unit.sv]
// min_coin_change_dp_unit: top level, sequencer over coin store and amount table
// depends on mccd_pkg, mccd_ram, mccd_relax
//
//  channel | direction | handshake              | fields
//  in      | input     | in_valid_i / in_stall_o | coin_value_i, target_amount_i, last_coin_i
//  out     | output    | out_valid_o / out_stall_i | reachable_o, coin_count_o
//
// a word without last_coin is only stored, while the coin store has room; a last word initialises
// amounts 0..target, then relaxes amounts c..target in turn for each usable held coin c, in the
// states ST_RDP, ST_RDC and ST_UPD per relaxation, set by the single read port of the amount table
// no clearing pass after reset; the table is rewritten over 0..target for each set
// input is stalled while a set is computed; a finished result waits in the output register
`timescale 1ns / 1ps

module min_coin_change_dp_unit
  import mccd_pkg::*;
#(
  parameter int unsigned MAX_AMOUNT = MAX_AMOUNT_DEF,
  parameter int unsigned MAX_COINS  = MAX_COINS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [COIN_W-1:0] coin_value_i,
  input  logic [AMT_W-1:0]  target_amount_i,
  input  logic              last_coin_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              reachable_o,
  output logic [OUT_W-1:0]  coin_count_o
);

  localparam int unsigned TAW = (MAX_AMOUNT + 1 > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
  localparam int unsigned CIW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int unsigned HW  = $clog2(MAX_COINS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_CRD  = 4'd2;
  localparam logic [3:0] ST_CCHK = 4'd3;
  localparam logic [3:0] ST_RDP  = 4'd4;
  localparam logic [3:0] ST_RDC  = 4'd5;
  localparam logic [3:0] ST_UPD  = 4'd6;
  localparam logic [3:0] ST_FRD  = 4'd7;
  localparam logic [3:0] ST_FRES = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [HW-1:0]    held_q, held_d;
  logic [HW-1:0]    k_q, k_d;
  logic [AMT_W-1:0] j_q, j_d;
  logic             over_q, over_d;
  logic             out_valid_q, out_valid_d;

  logic [AMT_W-1:0] target_q, target_d;
  logic [AMT_W-1:0] coin_q, coin_d;
  logic [CNT_W-1:0] prev_q, prev_d;
  logic             reach_q, reach_d;
  logic [OUT_W-1:0] count_q, count_d;

  logic              in_acc;
  logic              coin_we;
  logic [COIN_W-1:0] coin_rdata;
  logic              tbl_we;
  logic [AMT_W-1:0]  tbl_raddr;
  logic [CNT_W-1:0]  tbl_wdata;
  logic [CNT_W-1:0]  tbl_rdata;
  relax_res_t        relax;
  logic              res_reach;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign coin_we = in_acc && (held_q < HW'(MAX_COINS));

  mccd_ram #(
    .Width (COIN_W),
    .Depth (MAX_COINS)
  ) u_coin_ram (
    .clk_i   (clk_i),
    .we_i    (coin_we),
    .waddr_i (held_q[CIW-1:0]),
    .wdata_i (coin_value_i),
    .raddr_i (k_q[CIW-1:0]),
    .rdata_o (coin_rdata)
  );

  mccd_ram #(
    .Width (CNT_W),
    .Depth (MAX_AMOUNT + 1)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (TAW'(j_q)),
    .wdata_i (tbl_wdata),
    .raddr_i (TAW'(tbl_raddr)),
    .rdata_o (tbl_rdata)
  );

  mccd_relax u_relax (
    .prev_i (prev_q),
    .cur_i  (tbl_rdata),
    .res_o  (relax)
  );

  assign res_reach = !over_q && (tbl_rdata < INF_MARK);

  always_comb begin
    unique case (state_q)
      ST_RDP:           tbl_raddr = AMT_W'(j_q - coin_q);
      ST_FRD, ST_FRES:  tbl_raddr = target_q;
      default:          tbl_raddr = j_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    k_d         = k_q;
    j_d         = j_q;
    over_d      = over_q;
    out_valid_d = out_valid_q && out_stall_i;
    target_d    = target_q;
    coin_d      = coin_q;
    prev_d      = prev_q;
    reach_d     = reach_q;
    count_d     = count_q;
    tbl_we      = 1'b0;
    tbl_wdata   = INF_MARK;
    in_stall_o  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (coin_we) begin
            held_d = HW'(held_q + 1'b1);
          end
          if (last_coin_i) begin
            target_d = target_amount_i;
            j_d      = '0;
            if (32'(target_amount_i) > 32'(MAX_AMOUNT)) begin
              over_d  = 1'b1;
              state_d = ST_FRES;
            end else begin
              over_d  = 1'b0;
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        tbl_we    = 1'b1;
        tbl_wdata = (j_q == '0) ? '0 : INF_MARK;
        if (j_q == target_q) begin
          k_d     = '0;
          state_d = ST_CRD;
        end else begin
          j_d = AMT_W'(j_q + 1'b1);
        end
      end
      ST_CRD: begin
        state_d = (k_q == held_q) ? ST_FRD : ST_CCHK;
      end
      ST_CCHK: begin
        k_d = HW'(k_q + 1'b1);
        if (coin_rdata == '0 || coin_rdata > COIN_W'(target_q)) begin
          state_d = ST_CRD;
        end else begin
          coin_d  = coin_rdata[AMT_W-1:0];
          j_d     = coin_rdata[AMT_W-1:0];
          state_d = ST_RDP;
        end
      end
      ST_RDP: begin
        state_d = ST_RDC;
      end
      ST_RDC: begin
        prev_d  = tbl_rdata;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        tbl_we    = relax.upd;
        tbl_wdata = relax.val;
        if (j_q == target_q) begin
          state_d = ST_CRD;
        end else begin
          j_d     = AMT_W'(j_q + 1'b1);
          state_d = ST_RDP;
        end
      end
      ST_FRD: begin
        state_d = ST_FRES;
      end
      ST_FRES: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          reach_d     = res_reach;
          count_d     = res_reach ? tbl_rdata[OUT_W-1:0] : '0;
          held_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      k_q         <= '0;
      j_q         <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      k_q         <= k_d;
      j_q         <= j_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    coin_q   <= coin_d;
    prev_q   <= prev_d;
    reach_q  <= reach_d;
    count_q  <= count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign reachable_o  = reach_q;
  assign coin_count_o = count_q;

  // a last word always starts a computation that stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_coin_i |=> in_stall_o)
    else $error("last word did not start computation");

  // coin count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(MAX_COINS))
    else $error("coin count beyond store depth");

  // table writes stay within the amounts of the current set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> j_q <= target_q)
    else $error("table write beyond target");

  // relaxation only runs with a nonzero coin no larger than the current amount
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> coin_q != '0 && coin_q <= j_q)
    else $error("relaxation with unusable coin");

  // unreachable word carries a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> coin_count_o == '0)
    else $error("unreachable word with nonzero count");

endmodule

[hdl/mccd_ram.sv]
// mccd_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mccd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mccd_relax.sv]
// mccd_relax: shared add and compare unit, one table relaxation step
// depends on mccd_pkg
`timescale 1ns / 1ps

module mccd_relax
  import mccd_pkg::*;
(
  input  logic [CNT_W-1:0] prev_i,
  input  logic [CNT_W-1:0] cur_i,
  output relax_res_t       res_o
);

  logic [CNT_W-1:0] cand;

  always_comb begin
    cand = (prev_i >= INF_MARK) ? INF_MARK : CNT_W'(prev_i + 1'b1);
    res_o.val = cand;
    res_o.upd = (cand < cur_i);
  end

endmodule
